// ===== hdl/bpra_pkg.sv =====
`default_nettype none
package bpra_pkg;
    localparam int ADDR_W = 48;
    localparam int SIZE_W = 25;
    localparam int CNT_W  = 13;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic we;
        logic wdata;
    } map_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/bpra_if.sv =====
`default_nettype none
interface bpra_req_if;
    import bpra_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [SIZE_W-1:0] size_bytes;
    logic [SIZE_W-1:0] alignment_bytes;
    logic [ADDR_W-1:0] free_address;
    modport source (output valid, cmd, size_bytes, alignment_bytes, free_address,
                    input ready);
    modport sink   (input valid, cmd, size_bytes, alignment_bytes, free_address,
                    output ready);
endinterface

interface bpra_rsp_if;
    import bpra_pkg::*;
    logic              valid;
    logic              ready;
    logic              ok;
    logic [ADDR_W-1:0] address_out;
    logic [CNT_W-1:0]  used_pages;
    modport source (output valid, ok, address_out, used_pages, input ready);
    modport sink   (input valid, ok, address_out, used_pages, output ready);
endinterface
`default_nettype wire

// ===== hdl/bitmap_page_range_allocator_top.sv =====
// Allocate: a prepare step, then one map read and one evaluate step per page scanned,
// then one mark step per page of the run; all go through the single map port.
// Free: prepare, find the start page, clear each page. One item in flight at a time.
// Reset clears the map in a pass over every page; no item is taken until it ends.
// used_pages and base_address reset to 0.
`default_nettype none
module bitmap_page_range_allocator_top
    import bpra_pkg::*;
#(
    parameter int NUM_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    bpra_req_if.sink         req,
    bpra_rsp_if.source       rsp
);
    logic [ADDR_W-1:0]            base_reg;
    logic [$clog2(NUM_PAGES)-1:0] map_addr;
    map_ctl_t                     map_ctl;
    logic                         map_rdata;
    logic                         init_done;

    assign pready = 1'b1;
    assign prdata = (paddr == 4'd0) ? 64'(base_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= '0;
        else if (psel && penable && pwrite && paddr == 4'd0)
            base_reg <= pwdata[ADDR_W-1:0];
    end

    bpra_engine #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_address (base_reg),
        .init_done    (init_done),
        .req          (req),
        .rsp          (rsp),
        .map_addr     (map_addr),
        .map_ctl      (map_ctl),
        .map_rdata    (map_rdata)
    );

    bpra_pagemap #(.NUM_PAGES(NUM_PAGES)) u_pagemap (
        .clk       (clk),
        .rst_n     (rst_n),
        .addr      (map_addr),
        .ctl       (map_ctl),
        .rdata     (map_rdata),
        .init_done (init_done)
    );
endmodule
`default_nettype wire

// ===== hdl/bpra_pagemap.sv =====
`default_nettype none
module bpra_pagemap
    import bpra_pkg::*;
#(
    parameter int NUM_PAGES = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [$clog2(NUM_PAGES)-1:0] addr,
    input  wire map_ctl_t                     ctl,
    output logic                              rdata,
    output logic                              init_done
);
    localparam int IW = $clog2(NUM_PAGES);
    localparam logic [IW-1:0] LAST = IW'(NUM_PAGES - 1);

    logic          mem [NUM_PAGES];
    logic          clr_busy_reg, clr_busy_next;
    logic [IW-1:0] clr_ptr_reg, clr_ptr_next;
    logic [IW-1:0] m_addr;
    logic          m_we, m_wd;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_ptr_next  = clr_ptr_reg;
        if (clr_busy_reg)
        begin
            clr_ptr_next = clr_ptr_reg + 1'b1;
            if (clr_ptr_reg == LAST)
                clr_busy_next = 1'b0;
        end
        m_addr = clr_busy_reg ? clr_ptr_reg : addr;
        m_we   = clr_busy_reg | ctl.we;
        m_wd   = clr_busy_reg ? 1'b0 : ctl.wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_ptr_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_ptr_reg  <= clr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
            mem[m_addr] <= m_wd;
        rdata <= mem[m_addr];
    end

    assign init_done = ~clr_busy_reg;
endmodule
`default_nettype wire

// ===== hdl/bpra_engine.sv =====
`default_nettype none
module bpra_engine
    import bpra_pkg::*;
#(
    parameter int NUM_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [ADDR_W-1:0]            base_address,
    input  wire logic                         init_done,
    bpra_req_if.sink                          req,
    bpra_rsp_if.source                        rsp,
    output logic [$clog2(NUM_PAGES)-1:0]      map_addr,
    output map_ctl_t                          map_ctl,
    input  wire logic                         map_rdata
);
    localparam int IW = $clog2(NUM_PAGES);
    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int PW = SIZE_W + 1;
    localparam logic [63:0]   TOTAL = 64'(NUM_PAGES) * 64'(PAGE_BYTES);
    localparam logic [PW-1:0] PB_M1 = PW'(PAGE_BYTES - 1);
    localparam logic [IW-1:0] LAST  = IW'(NUM_PAGES - 1);
    localparam logic [ADDR_W-1:0] NP_A = ADDR_W'(NUM_PAGES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EV    = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_FPREP = 3'd5;
    localparam logic [2:0] S_FCALC = 3'd6;
    localparam logic [2:0] S_CLR   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic              busy_out_reg, busy_out_next;
    logic [SIZE_W-1:0] size_reg, algn_reg;
    logic [ADDR_W-1:0] faddr_reg;
    logic [PW-1:0]     need_reg, need_next;
    logic [PW-1:0]     align_reg, align_next;
    logic [PW-1:0]     phase_reg, phase_next;
    logic [CW-1:0]     run_reg, run_next;
    logic [IW-1:0]     p_reg, p_next;
    logic [IW-1:0]     first_reg, first_next;
    logic [ADDR_W-1:0] fstart_reg, fstart_next;
    logic [PW-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic              ok_reg, ok_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic [PW-1:0]     sz_pg, al_pg;
    logic [CW-1:0]     run_new;
    logic [PW:0]       sum;
    logic [ADDR_W-1:0] avail;

    always_comb
    begin
        state_next    = state_reg;
        busy_out_next = busy_out_reg;
        need_next     = need_reg;
        align_next    = align_reg;
        phase_next    = phase_reg;
        run_next      = run_reg;
        p_next        = p_reg;
        first_next    = first_reg;
        fstart_next   = fstart_reg;
        rem_next      = rem_reg;
        used_next     = used_reg;
        ok_next       = ok_reg;
        addr_next     = addr_reg;
        map_addr      = p_reg;
        map_ctl       = '0;
        sz_pg   = PW'((PW'(size_reg) + PB_M1) / PAGE_BYTES);
        al_pg   = PW'((PW'(algn_reg) + PB_M1) / PAGE_BYTES);
        run_new = '0;
        sum     = '0;
        avail   = '0;

        if (busy_out_reg && rsp.ready)
            busy_out_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                    state_next = (req.cmd == CMD_ALLOC) ? S_PREP : S_FPREP;
            end
            S_PREP:
            begin
                need_next  = sz_pg;
                align_next = (al_pg == '0) ? PW'(1) : al_pg;
                phase_next = '0;
                run_next   = '0;
                p_next     = '0;
                ok_next    = 1'b0;
                addr_next  = '0;
                if (size_reg != '0 && 64'(size_reg) <= TOTAL)
                    state_next = S_RD;
                else
                begin
                    state_next    = S_IDLE;
                    busy_out_next = 1'b1;
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                run_new = '0;
                if (!map_rdata)
                begin
                    if (run_reg == '0)
                    begin
                        if (phase_reg == '0)
                        begin
                            first_next = p_reg;
                            run_new    = CW'(1);
                        end
                    end
                    else
                        run_new = run_reg + 1'b1;
                end
                run_next   = run_new;
                phase_next = (phase_reg + 1'b1 == align_reg) ? '0 : phase_reg + 1'b1;
                p_next     = p_reg + 1'b1;
                if (run_new != '0 && PW'(run_new) >= need_reg)
                begin
                    first_next = (run_reg == '0) ? p_reg : first_reg;
                    p_next     = (run_reg == '0) ? p_reg : first_reg;
                    rem_next   = need_reg;
                    state_next = S_MARK;
                end
                else if (p_reg == LAST)
                begin
                    state_next    = S_IDLE;
                    busy_out_next = 1'b1;
                end
                else
                    state_next = S_RD;
            end
            S_MARK:
            begin
                map_ctl.we    = 1'b1;
                map_ctl.wdata = 1'b1;
                p_next   = p_reg + 1'b1;
                rem_next = rem_reg - 1'b1;
                if (rem_reg == PW'(1))
                begin
                    sum       = (PW+1)'(used_reg) + (PW+1)'(need_reg);
                    used_next = (sum > (PW+1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
                    ok_next   = 1'b1;
                    addr_next = base_address + ADDR_W'(first_reg) * ADDR_W'(PAGE_BYTES);
                    state_next    = S_IDLE;
                    busy_out_next = 1'b1;
                end
            end
            S_FPREP:
            begin
                ok_next     = 1'b0;
                addr_next   = '0;
                need_next   = sz_pg;
                fstart_next = ADDR_W'((faddr_reg - base_address) / PAGE_BYTES);
                if (faddr_reg >= base_address && size_reg != '0)
                begin
                    ok_next    = 1'b1;
                    used_next  = ((PW)'(used_reg) > sz_pg) ? used_reg - CNT_W'(sz_pg) : '0;
                    state_next = S_FCALC;
                end
                else
                begin
                    state_next    = S_IDLE;
                    busy_out_next = 1'b1;
                end
            end
            S_FCALC:
            begin
                avail  = NP_A - fstart_reg;
                p_next = fstart_reg[IW-1:0];
                if (fstart_reg >= NP_A)
                begin
                    state_next    = S_IDLE;
                    busy_out_next = 1'b1;
                end
                else
                begin
                    rem_next   = (ADDR_W'(need_reg) < avail) ? need_reg : PW'(avail);
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                map_ctl.we    = 1'b1;
                map_ctl.wdata = 1'b0;
                p_next   = p_reg + 1'b1;
                rem_next = rem_reg - 1'b1;
                if (rem_reg == PW'(1))
                begin
                    state_next    = S_IDLE;
                    busy_out_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            busy_out_reg <= 1'b0;
            used_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            busy_out_reg <= busy_out_next;
            used_reg     <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            size_reg  <= req.size_bytes;
            algn_reg  <= req.alignment_bytes;
            faddr_reg <= req.free_address;
        end
        need_reg   <= need_next;
        align_reg  <= align_next;
        phase_reg  <= phase_next;
        run_reg    <= run_next;
        p_reg      <= p_next;
        first_reg  <= first_next;
        fstart_reg <= fstart_next;
        rem_reg    <= rem_next;
        ok_reg     <= ok_next;
        addr_reg   <= addr_next;
    end

    assign req.ready       = (state_reg == S_IDLE) && !busy_out_reg && init_done;
    assign rsp.valid       = busy_out_reg;
    assign rsp.ok          = ok_reg;
    assign rsp.address_out = addr_reg;
    assign rsp.used_pages  = used_reg;
endmodule
`default_nettype wire

// ===== hdl/bpra_checker.sv =====
`default_nettype none
module bpra_checker
    import bpra_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic              rsp_ok,
    input wire logic [ADDR_W-1:0] rsp_address_out,
    input wire logic [CNT_W-1:0]  rsp_used_pages
);
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while result pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("ready after transfer");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ok) |-> (rsp_address_out == '0))
        else $error("failed result carries address");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_used_pages)))
        else $error("result dropped while stalled");
endmodule

bind bitmap_page_range_allocator_top bpra_checker u_bpra_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_ok          (rsp.ok),
    .rsp_address_out (rsp.address_out),
    .rsp_used_pages  (rsp.used_pages)
);
`default_nettype wire
